// ----- src/ofzf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofzf_pkg
// Shared widths, register indexes and the beat type of the divider chain.
// ----------------------------------------------------------------------------
package ofzf_pkg;

   // Input sample and output symbol widths
   localparam int SampleWidth  = 16;
   localparam int CarrierWidth = 10;
   localparam int NoiseWidth   = 32;

   // Channel power (Q4.28, unsigned) plus noise term
   localparam int PowerWidth = 32;
   localparam int DenWidth   = 34;
   // Numerator magnitude, dividend (mag * 2048 + den) and divisor (2 * den)
   localparam int MagWidth   = 32;
   localparam int RemWidth   = 44;
   localparam int DvsWidth   = DenWidth + 1;
   // Quotient bits: 16 result bits plus two for overflow detection
   localparam int QuoWidth   = 18;
   localparam int CmpWidth   = DvsWidth + QuoWidth;

   // Register indexes
   localparam logic CsrEqMode       = 1'b0;
   localparam logic CsrNoiseInverse = 1'b1;

   typedef struct packed {
      logic [RemWidth-1:0]     rem_re;
      logic [RemWidth-1:0]     rem_im;
      logic [DvsWidth-1:0]     dvs;
      logic [QuoWidth-1:0]     q_re;
      logic [QuoWidth-1:0]     q_im;
      logic                    neg_re;
      logic                    neg_im;
      logic                    zero;
      logic [CarrierWidth-1:0] carrier;
      logic                    last;
   } div_beat_type;

endpackage

// ----- src/ofzf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofzf_front
// Two pipeline stages: complex products, then numerator, denominator and the
// first divider beat.
// ----------------------------------------------------------------------------
module ofzf_front
   import ofzf_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           eq_mode,
   input  logic [NoiseWidth-1:0]          noise_inverse,
   input  logic                           valid_i,
   output logic                           ready_o,
   input  logic signed [SampleWidth-1:0]  y_re,
   input  logic signed [SampleWidth-1:0]  y_im,
   input  logic signed [SampleWidth-1:0]  h_re,
   input  logic signed [SampleWidth-1:0]  h_im,
   input  logic [CarrierWidth-1:0]        carrier_i,
   input  logic                           last_i,
   output logic                           valid_o,
   input  logic                           ready_i,
   output div_beat_type                   beat_o
);

   localparam int ProdWidth = 2 * SampleWidth;

   logic                          valid_a_ff, valid_a_in;
   logic                          valid_b_ff, valid_b_in;
   logic                          ready_a;
   logic signed [ProdWidth-1:0]   p_yrhr_ff, p_yihi_ff, p_yihr_ff, p_yrhi_ff;
   logic signed [ProdWidth-1:0]   p_hrhr_ff, p_hihi_ff;
   logic [CarrierWidth-1:0]       carrier_a_ff;
   logic                          last_a_ff;
   div_beat_type                  beat_b_ff, beat_b_in;

   logic signed [ProdWidth:0]     num_re, num_im;
   logic [PowerWidth-1:0]         power;
   logic [DenWidth-1:0]           den;
   logic [MagWidth-1:0]           mag_re, mag_im;

   // Stage handshake: a stage takes a beat when empty or draining
   assign ready_a = !valid_b_ff || ready_i;
   assign ready_o = !valid_a_ff || ready_a;
   assign valid_a_in = ready_o ? valid_i : valid_a_ff;
   assign valid_b_in = ready_a ? valid_a_ff : valid_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   // Stage A: register the six products
   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         p_yrhr_ff    <= y_re * h_re;
         p_yihi_ff    <= y_im * h_im;
         p_yihr_ff    <= y_im * h_re;
         p_yrhi_ff    <= y_re * h_im;
         p_hrhr_ff    <= h_re * h_re;
         p_hihi_ff    <= h_im * h_im;
         carrier_a_ff <= carrier_i;
         last_a_ff    <= last_i;
      end
   end

   // Stage B: numerator, denominator, dividend and divisor
   always_comb begin
      num_re = (ProdWidth+1)'(p_yrhr_ff) + (ProdWidth+1)'(p_yihi_ff);
      num_im = (ProdWidth+1)'(p_yihr_ff) - (ProdWidth+1)'(p_yrhi_ff);
      power  = PowerWidth'(p_hrhr_ff) + PowerWidth'(p_hihi_ff);
      den    = DenWidth'(power) + (eq_mode ? DenWidth'(noise_inverse) : DenWidth'(0));
      mag_re = num_re[ProdWidth] ? MagWidth'(-num_re) : MagWidth'(num_re);
      mag_im = num_im[ProdWidth] ? MagWidth'(-num_im) : MagWidth'(num_im);

      beat_b_in.rem_re  = RemWidth'({mag_re, 11'b0}) + RemWidth'(den);
      beat_b_in.rem_im  = RemWidth'({mag_im, 11'b0}) + RemWidth'(den);
      beat_b_in.dvs     = {den, 1'b0};
      beat_b_in.q_re    = '0;
      beat_b_in.q_im    = '0;
      beat_b_in.neg_re  = num_re[ProdWidth];
      beat_b_in.neg_im  = num_im[ProdWidth];
      beat_b_in.zero    = (den == '0);
      beat_b_in.carrier = carrier_a_ff;
      beat_b_in.last    = last_a_ff;
   end

   always_ff @(posedge clock) begin
      if (ready_a && valid_a_ff) begin
         beat_b_ff <= beat_b_in;
      end
   end

   assign valid_o = valid_b_ff;
   assign beat_o  = beat_b_ff;

endmodule

// ----- src/ofzf_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofzf_div_cell
// One restoring-division cell: settles one quotient bit of both parts and
// hands the beat to its neighbour.
// ----------------------------------------------------------------------------
module ofzf_div_cell
   import ofzf_pkg::*;
#(
   parameter int BitPos = 0
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_i,
   output logic          ready_o,
   input  div_beat_type  beat_i,
   output logic          valid_o,
   input  logic          ready_i,
   output div_beat_type  beat_o
);

   logic                 valid_ff, valid_in;
   div_beat_type         beat_ff, beat_in;
   logic [CmpWidth-1:0]  trial;
   logic                 ge_re, ge_im;

   assign ready_o  = !valid_ff || ready_i;
   assign valid_in = ready_o ? valid_i : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Compare against the shifted divisor, subtract where it fits
   always_comb begin
      trial = CmpWidth'(beat_i.dvs) << BitPos;
      ge_re = CmpWidth'(beat_i.rem_re) >= trial;
      ge_im = CmpWidth'(beat_i.rem_im) >= trial;
      beat_in = beat_i;
      if (ge_re) begin
         beat_in.rem_re = beat_i.rem_re - trial[RemWidth-1:0];
      end
      if (ge_im) begin
         beat_in.rem_im = beat_i.rem_im - trial[RemWidth-1:0];
      end
      beat_in.q_re[BitPos] = ge_re;
      beat_in.q_im[BitPos] = ge_im;
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         beat_ff <= beat_in;
      end
   end

   assign valid_o = valid_ff;
   assign beat_o  = beat_ff;

endmodule

// ----- src/ofzf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofzf_back
// Output stage: sign, clip and zero-denominator forcing into the result
// register.
// ----------------------------------------------------------------------------
module ofzf_back
   import ofzf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_i,
   output logic                          ready_o,
   input  div_beat_type                  beat_i,
   output logic                          valid_o,
   input  logic                          stall_i,
   output logic signed [SampleWidth-1:0] x_re,
   output logic signed [SampleWidth-1:0] x_im,
   output logic [CarrierWidth-1:0]       carrier_o,
   output logic                          last_o,
   output logic                          zero_o,
   output logic                          sat_o
);

   logic                    valid_ff, valid_in;
   logic [SampleWidth-1:0]  x_re_ff, x_re_in, x_im_ff, x_im_in;
   logic [CarrierWidth-1:0] carrier_ff;
   logic                    last_ff, zero_ff, sat_ff, sat_in;
   logic                    sat_re, sat_im;

   function automatic logic [SampleWidth-1:0] clip(input logic [QuoWidth-1:0] q,
                                                   input logic neg,
                                                   output logic sat);
      logic [QuoWidth-1:0] neg_q;
      begin
         neg_q = -q;
         if (!neg) begin
            sat = (q[QuoWidth-1:SampleWidth-1] != '0);
            clip = sat ? {1'b0, {(SampleWidth-1){1'b1}}} : q[SampleWidth-1:0];
         end else begin
            sat = (q[QuoWidth-1:SampleWidth] != '0) ||
                  (q[SampleWidth-1] && (q[SampleWidth-2:0] != '0));
            clip = sat ? {1'b1, {(SampleWidth-1){1'b0}}} : neg_q[SampleWidth-1:0];
         end
      end
   endfunction

   assign ready_o  = !valid_ff || !stall_i;
   assign valid_in = ready_o ? valid_i : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Round-to-nearest is already folded into the dividend; clip here
   always_comb begin
      x_re_in = clip(beat_i.q_re, beat_i.neg_re, sat_re);
      x_im_in = clip(beat_i.q_im, beat_i.neg_im, sat_im);
      sat_in  = sat_re || sat_im;
      if (beat_i.zero) begin
         x_re_in = '0;
         x_im_in = '0;
         sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         x_re_ff    <= x_re_in;
         x_im_ff    <= x_im_in;
         carrier_ff <= beat_i.carrier;
         last_ff    <= beat_i.last;
         zero_ff    <= beat_i.zero;
         sat_ff     <= sat_in;
      end
   end

   assign valid_o   = valid_ff;
   assign x_re      = x_re_ff;
   assign x_im      = x_im_ff;
   assign carrier_o = carrier_ff;
   assign last_o    = last_ff;
   assign zero_o    = zero_ff;
   assign sat_o     = sat_ff;

endmodule

// ----- src/ofdm_zf_mmse_equalizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdm_zf_mmse_equalizer
// One-tap zero-forcing / MMSE equaliser for OFDM data carriers.
// ----------------------------------------------------------------------------
// Usage: each req_ beat carries a received sample Y, a channel estimate H
// (both Q1.14), a carrier number and an end-of-symbol mark. Each rsp_ beat
// returns conj(H)*Y / D in Q5.10, rounded and clipped, with the carrier
// number and mark passed through, one result per request, in order.
// D is |H|^2, plus the csr_ noise term when eq_mode is set.
// Path from request to result: multiply and set-up stages, a chain of 18
// division cells (one quotient bit each) and the output register.
// Throughput: one beat per clock while req_stall is low.
// A stalled rsp_ beat holds; earlier stages keep filling their empty slots
// and req_stall rises only when every stage is occupied.
// Reset clears all valid flags and sets eq_mode and noise_inverse to zero.
// Write configuration only while no beat is in flight.
// ----------------------------------------------------------------------------
module ofdm_zf_mmse_equalizer
   import ofzf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SampleWidth-1:0] req_y_re,
   input  logic signed [SampleWidth-1:0] req_y_im,
   input  logic signed [SampleWidth-1:0] req_h_re,
   input  logic signed [SampleWidth-1:0] req_h_im,
   input  logic [CarrierWidth-1:0]       req_carrier_index,
   input  logic                          req_last_carrier,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SampleWidth-1:0] rsp_x_re,
   output logic signed [SampleWidth-1:0] rsp_x_im,
   output logic [CarrierWidth-1:0]       rsp_carrier_out,
   output logic                          rsp_last_out,
   output logic                          rsp_zero_denominator,
   output logic                          rsp_saturated,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [NoiseWidth-1:0]         csr_data
);

   logic                  eq_mode_ff;
   logic [NoiseWidth-1:0] noise_inverse_ff;
   logic                  front_ready;

   logic                  chain_valid [QuoWidth+1];
   logic                  chain_ready [QuoWidth+1];
   div_beat_type          chain_beat  [QuoWidth+1];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         eq_mode_ff       <= 1'b0;
         noise_inverse_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrEqMode:       eq_mode_ff       <= csr_data[0];
            CsrNoiseInverse: noise_inverse_ff <= csr_data;
            default:         eq_mode_ff       <= eq_mode_ff;
         endcase
      end
   end

   assign req_stall = !front_ready;

   ofzf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .eq_mode       (eq_mode_ff),
      .noise_inverse (noise_inverse_ff),
      .valid_i       (req_valid),
      .ready_o       (front_ready),
      .y_re          (req_y_re),
      .y_im          (req_y_im),
      .h_re          (req_h_re),
      .h_im          (req_h_im),
      .carrier_i     (req_carrier_index),
      .last_i        (req_last_carrier),
      .valid_o       (chain_valid[0]),
      .ready_i       (chain_ready[0]),
      .beat_o        (chain_beat[0])
   );

   // Division chain, most significant quotient bit first
   for (genvar i = 0; i < QuoWidth; i++) begin : g_cell
      ofzf_div_cell #(
         .BitPos (QuoWidth - 1 - i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (chain_valid[i]),
         .ready_o (chain_ready[i]),
         .beat_i  (chain_beat[i]),
         .valid_o (chain_valid[i+1]),
         .ready_i (chain_ready[i+1]),
         .beat_o  (chain_beat[i+1])
      );
   end

   ofzf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (chain_valid[QuoWidth]),
      .ready_o   (chain_ready[QuoWidth]),
      .beat_i    (chain_beat[QuoWidth]),
      .valid_o   (rsp_valid),
      .stall_i   (rsp_stall),
      .x_re      (rsp_x_re),
      .x_im      (rsp_x_im),
      .carrier_o (rsp_carrier_out),
      .last_o    (rsp_last_out),
      .zero_o    (rsp_zero_denominator),
      .sat_o     (rsp_saturated)
   );

endmodule

// ----- dv/tb_ofdm_zf_mmse_equalizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ofdm_zf_mmse_equalizer
// Self-checking bench for the one-tap ZF / MMSE equaliser: a directed table
// of corner beats, then random beats over several register settings, each
// result checked field by field against a typed-in value or a bit-exact
// predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ofdm_zf_mmse_equalizer;
   import ofzf_pkg::*;

   localparam int Latency   = 21;
   localparam int WatchLimit = 20000;
   localparam int NumRows    = 14;

   typedef struct packed {
      logic signed [SampleWidth-1:0] y_re;
      logic signed [SampleWidth-1:0] y_im;
      logic signed [SampleWidth-1:0] h_re;
      logic signed [SampleWidth-1:0] h_im;
      logic [CarrierWidth-1:0]       carrier;
      logic                          last;
   } carrier_beat_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] x_re;
      logic signed [SampleWidth-1:0] x_im;
      logic [CarrierWidth-1:0]       carrier;
      logic                          last;
      logic                          zero;
      logic                          sat;
   } symbol_beat_type;

   // Directed row: beat, whether the result is typed in, and the result
   typedef struct packed {
      carrier_beat_type beat;
      logic             known;
      symbol_beat_type  want;
   } corner_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SampleWidth-1:0] req_y_re = '0, req_y_im = '0, req_h_re = '0, req_h_im = '0;
   logic [CarrierWidth-1:0] req_carrier_index = '0;
   logic req_last_carrier = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SampleWidth-1:0] rsp_x_re, rsp_x_im;
   logic [CarrierWidth-1:0] rsp_carrier_out;
   logic rsp_last_out, rsp_zero_denominator, rsp_saturated;
   logic csr_write_enable = 1'b0;
   logic csr_index = CsrEqMode;
   logic [NoiseWidth-1:0] csr_data = '0;

   ofdm_zf_mmse_equalizer u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor copy of the registers
   logic                  mode_mmse;
   logic [NoiseWidth-1:0] noise_term;

   symbol_beat_type symbols_due[$];
   int  failures   = 0;
   int  idle_pct   = 28;
   int  idle_count = 0;
   bit  timed_out  = 1'b0;

   // Round n*1024/d to nearest, ties away, clip to 16 bits
   function automatic logic [15:0] scale_q510(input longint n, input longint d,
                                              inout logic sat);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (mag * 2048 + d) / (d * 2);
      if (n >= 0) begin
         if (q > 32767) begin
            q = 32767;
            sat = 1'b1;
         end
         return q[15:0];
      end
      if (q > 32768) begin
         q = 32768;
         sat = 1'b1;
      end
      q = -q;
      return q[15:0];
   endfunction

   function automatic symbol_beat_type equalise(input carrier_beat_type b);
      symbol_beat_type r;
      longint yr, yi, hr, hi, den;
      logic sat;
      yr = b.y_re;
      yi = b.y_im;
      hr = b.h_re;
      hi = b.h_im;
      sat = 1'b0;
      den = hr * hr + hi * hi;
      if (mode_mmse) den += longint'(noise_term);
      r.carrier = b.carrier;
      r.last = b.last;
      if (den == 0) begin
         r.x_re = '0;
         r.x_im = '0;
         r.zero = 1'b1;
      end else begin
         r.x_re = scale_q510(yr * hr + yi * hi, den, sat);
         r.x_im = scale_q510(yi * hr - yr * hi, den, sat);
         r.zero = 1'b0;
      end
      r.sat = sat;
      return r;
   endfunction

   task automatic write_reg(input logic idx, input logic [NoiseWidth-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CsrEqMode) mode_mmse = value[0];
      else noise_term = value;
   endtask

   // Drive one beat, hold it until accepted, then queue its expectation
   task automatic send_beat(input carrier_beat_type b, input logic known,
                            input symbol_beat_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_y_re, req_y_im, req_h_re, req_h_im, req_carrier_index, req_last_carrier} <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      symbols_due.push_back(known ? want : equalise(b));
   endtask

   // Drop the request and wait for every expected result
   task automatic drain();
      req_valid <= 1'b0;
      while (symbols_due.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(15) - 8);
         3: return 16'(32'h4000 + $urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int n);
      carrier_beat_type b;
      for (int i = 0; i < n; i++) begin
         b.y_re = rand_sample();
         b.y_im = rand_sample();
         b.h_re = ($urandom_range(19) == 0) ? '0 : rand_sample();
         b.h_im = ($urandom_range(19) == 0) ? '0 : rand_sample();
         b.carrier = CarrierWidth'($urandom);
         b.last = ($urandom_range(7) == 0);
         send_beat(b, 1'b0, '0);
      end
   endtask

   // Random stall on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      symbol_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (symbols_due.size() == 0) begin
            $error("result with nothing expected: carrier %0d", rsp_carrier_out);
            failures++;
         end else begin
            want = symbols_due.pop_front();
            if (rsp_x_re !== want.x_re) begin
               $error("x_re: expected %0d, got %0d", want.x_re, rsp_x_re);
               failures++;
            end
            if (rsp_x_im !== want.x_im) begin
               $error("x_im: expected %0d, got %0d", want.x_im, rsp_x_im);
               failures++;
            end
            if (rsp_carrier_out !== want.carrier) begin
               $error("carrier_out: expected %0d, got %0d", want.carrier, rsp_carrier_out);
               failures++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out: expected %0b, got %0b", want.last, rsp_last_out);
               failures++;
            end
            if (rsp_zero_denominator !== want.zero) begin
               $error("zero_denominator: expected %0b, got %0b", want.zero,
                      rsp_zero_denominator);
               failures++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated: expected %0b, got %0b", want.sat, rsp_saturated);
               failures++;
            end
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WatchLimit) timed_out <= 1'b1;
   end

   initial begin
      corner_row_type corners[NumRows];
      // Corner beats; rows 0 to 5 have results that read straight off the arithmetic
      corners[0]  = '{'{16'sh4000, 16'sh0, 16'sh4000, 16'sh0, 10'd0, 1'b0}, 1'b1,
                      '{16'sd1024, 16'sd0, 10'd0, 1'b0, 1'b0, 1'b0}};
      corners[1]  = '{'{16'sh0, 16'sh4000, 16'sh4000, 16'sh0, 10'd1023, 1'b1}, 1'b1,
                      '{16'sd0, 16'sd1024, 10'd1023, 1'b1, 1'b0, 1'b0}};
      corners[2]  = '{'{16'sh7fff, 16'sh7fff, 16'sh0, 16'sh0, 10'd5, 1'b0}, 1'b1,
                      '{16'sd0, 16'sd0, 10'd5, 1'b0, 1'b1, 1'b0}};
      corners[3]  = '{'{16'sh7fff, 16'sh0, 16'sh1, 16'sh0, 10'd6, 1'b1}, 1'b1,
                      '{16'sh7fff, 16'sd0, 10'd6, 1'b1, 1'b0, 1'b1}};
      corners[4]  = '{'{16'sh8000, 16'sh0, 16'sh1, 16'sh0, 10'd7, 1'b0}, 1'b1,
                      '{16'sh8000, 16'sd0, 10'd7, 1'b0, 1'b0, 1'b1}};
      corners[5]  = '{'{16'sh0, 16'sh0, 16'sh8000, 16'sh8000, 10'd8, 1'b0}, 1'b1,
                      '{16'sd0, 16'sd0, 10'd8, 1'b0, 1'b0, 1'b0}};
      corners[6]  = '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 10'd9, 1'b0},
                      1'b0, '0};
      corners[7]  = '{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 10'd10, 1'b1},
                      1'b0, '0};
      corners[8]  = '{'{16'sh1234, 16'shedcb, 16'sh0001, 16'shffff, 10'd11, 1'b0},
                      1'b0, '0};
      corners[9]  = '{'{16'sh7fff, 16'sh7fff, 16'shffff, 16'sh0, 10'd12, 1'b0},
                      1'b0, '0};
      corners[10] = '{'{16'sh0003, 16'shfffd, 16'sh0002, 16'sh0, 10'd13, 1'b0},
                      1'b0, '0};
      corners[11] = '{'{16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa, 10'h2aa, 1'b1},
                      1'b0, '0};
      corners[12] = '{'{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 10'h155, 1'b0},
                      1'b0, '0};
      corners[13] = '{'{16'sh2000, 16'shc000, 16'sh3fff, 16'shc001, 10'd14, 1'b1},
                      1'b0, '0};

      mode_mmse = 1'b0;
      noise_term = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the table at reset values (zero-forcing)
      foreach (corners[i]) send_beat(corners[i].beat, corners[i].known, corners[i].want);
      drain();

      // MMSE with zero noise still sees a zero denominator
      write_reg(CsrEqMode, 32'hffff_fffe);
      write_reg(CsrEqMode, 32'h1);
      foreach (corners[i]) send_beat(corners[i].beat, 1'b0, '0);
      drain();

      // Long burst with no idling, zero-forcing
      write_reg(CsrEqMode, 32'h0);
      idle_pct = 0;
      random_phase(150);
      idle_pct = 28;
      // Hold the sender until everything is back
      drain();
      random_phase(200);
      drain();

      // MMSE at several noise settings, extremes included
      write_reg(CsrEqMode, 32'h1);
      write_reg(CsrNoiseInverse, 32'hffff_ffff);
      foreach (corners[i]) send_beat(corners[i].beat, 1'b0, '0);
      random_phase(100);
      drain();
      write_reg(CsrNoiseInverse, 32'h1);
      random_phase(150);
      drain();
      write_reg(CsrNoiseInverse, 32'h0100_0000);
      random_phase(150);
      drain();
      write_reg(CsrNoiseInverse, $urandom);
      random_phase(100);
      drain();

      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      wait (timed_out);
      $display("FAIL");
      $finish;
   end

endmodule
